@@ src/line_of_sight_angles_core_defines.svh @@
// assertion macros for the line of sight angles core
// no dependencies; included by the top level
`ifndef LINE_OF_SIGHT_ANGLES_CORE_DEFINES_SVH
`define LINE_OF_SIGHT_ANGLES_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LOSA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LOSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/losa_pkg.sv @@
// shared types and constants for the line of sight angles core
// no dependencies
package losa_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_TAB_LEN      = 24;
    localparam int ANGLE_W           = 16;
    localparam int ACC_W             = 32;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 48;

    // quarter turn (pi/2) as a binary angle
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 16'sd16384;

    // atan(2^-i), 2^32 is one full turn
    localparam logic [ACC_W-1:0] ATAN_TAB [ATAN_TAB_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_X = 3'd0,
        CFG_POS_Y = 3'd1,
        CFG_POS_Z = 3'd2,
        CFG_ROW0  = 3'd3,
        CFG_ROW1  = 3'd4,
        CFG_ROW2  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
    } target_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] azimuth;
        logic signed [ANGLE_W-1:0] elevation;
        logic                      degenerate;
    } angles_t;

    // round a full-turn accumulator to a 16 bit binary angle
    function automatic logic [ANGLE_W-1:0] round16(input logic [ACC_W-1:0] acc);
        logic [ACC_W-1:0] sum;
        sum = acc + 32'h0000_8000;
        return sum[ACC_W-1:ACC_W-ANGLE_W];
    endfunction

endpackage

@@ src/losa_cordic.sv @@
// pipelined vectoring cordic, one rotation per register stage
// depends on losa_pkg
module losa_cordic #(
    parameter int W      = 32,
    parameter int STAGES = 16,
    parameter int TAG_W  = 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [W-1:0]      x,
    input  logic signed [W-1:0]      y,
    input  logic [TAG_W-1:0]         tag,
    output logic                     out_valid,
    output logic [losa_pkg::ACC_W-1:0] acc,
    output logic [TAG_W-1:0]         out_tag
);
    import losa_pkg::*;

    localparam int IW = W + 2;

    logic signed [IW-1:0] x_reg [0:STAGES];
    logic signed [IW-1:0] y_reg [0:STAGES];
    logic [ACC_W-1:0]     a_reg [0:STAGES];
    logic                 z_reg [0:STAGES];
    logic [TAG_W-1:0]     t_reg [0:STAGES];
    logic                 v_reg [0:STAGES];

    logic signed [IW-1:0] xw;
    logic signed [IW-1:0] yw;

    assign xw = IW'(x);
    assign yw = IW'(y);

    // prerotate by a half turn for the left half plane
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg[0] <= (x == '0) && (y == '0);
            t_reg[0] <= tag;
            if (x[W-1])
            begin
                x_reg[0] <= -xw;
                y_reg[0] <= -yw;
                a_reg[0] <= 32'h8000_0000;
            end
            else
            begin
                x_reg[0] <= xw;
                y_reg[0] <= yw;
                a_reg[0] <= '0;
            end
        end
    end

    for (genvar k = 1; k <= STAGES; k++)
    begin : g_stage
        logic signed [IW-1:0] xs;
        logic signed [IW-1:0] ys;

        assign xs = x_reg[k-1] >>> (k - 1);
        assign ys = y_reg[k-1] >>> (k - 1);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                z_reg[k] <= z_reg[k-1];
                t_reg[k] <= t_reg[k-1];
                if (!y_reg[k-1][IW-1])
                begin
                    x_reg[k] <= x_reg[k-1] + ys;
                    y_reg[k] <= y_reg[k-1] - xs;
                    a_reg[k] <= a_reg[k-1] + ATAN_TAB[k-1];
                end
                else
                begin
                    x_reg[k] <= x_reg[k-1] - ys;
                    y_reg[k] <= y_reg[k-1] + xs;
                    a_reg[k] <= a_reg[k-1] - ATAN_TAB[k-1];
                end
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign acc       = z_reg[STAGES] ? '0 : a_reg[STAGES];
    assign out_tag   = t_reg[STAGES];

endmodule

@@ src/line_of_sight_angles_core.sv @@
// top level of the line of sight angles core
// depends on losa_pkg, losa_cordic and line_of_sight_angles_core_defines.svh
//
// usage
//   target beat: a world point (target_x/y/z), taken when target_valid is
//   high and target_stall is low. angles beat: azimuth, elevation and the
//   degenerate flag, taken when angles_valid is high and angles_stall low.
//   the user writes vehicle position and attitude rows via the config port only while idle; the block trusts this.
// throughput: one beat per cycle while target_stall is low; the pipeline never blocks on its own work
// path: a target beat runs to its angles beat through the two cordic chains and
//   the 30-stage square root
// reset: all valid bits clear, position zero, attitude identity
// stall: a two-entry output (register plus skid) absorbs the beat in flight;
//   target_stall rises only once the skid entry is full, and then the whole
//   pipeline holds until the receiver drains it
`include "line_of_sight_angles_core_defines.svh"

module line_of_sight_angles_core #(
    parameter int CORDIC_STAGES = losa_pkg::CORDIC_STAGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            target_valid,
    output logic                            target_stall,
    input  losa_pkg::target_t               target,
    output logic                            angles_valid,
    input  logic                            angles_stall,
    output losa_pkg::angles_t               angles,
    input  logic                            cfg_we,
    input  logic [losa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [losa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import losa_pkg::*;

    localparam int DW    = 33;   // world difference
    localparam int PW    = 49;   // one matrix product
    localparam int BW    = 51;   // body vector component
    localparam int SW    = 29;   // scaled magnitude
    localparam int SQW   = 59;   // sum of squares
    localparam int RT_ST = 30;   // square root stages, one result bit each
    localparam int RW    = 30;   // root width
    localparam int EW    = 31;   // elevation cordic input width

    typedef struct packed {
        logic [SW-1:0]        xs;
        logic [SW-1:0]        zs;
        logic signed [SW:0]   ys;
        logic                 zero;
    } az_tag_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] az;
        logic               zero;
    } el_tag_t;

    // configuration registers
    logic signed [31:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [47:0]        row_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            pos_z_reg  <= '0;
            row_reg[0] <= 48'h0000_0000_4000;
            row_reg[1] <= 48'h0000_4000_0000;
            row_reg[2] <= 48'h4000_0000_0000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POS_X: pos_x_reg  <= cfg_data[31:0];
                CFG_POS_Y: pos_y_reg  <= cfg_data[31:0];
                CFG_POS_Z: pos_z_reg  <= cfg_data[31:0];
                CFG_ROW0:  row_reg[0] <= cfg_data;
                CFG_ROW1:  row_reg[1] <= cfg_data;
                CFG_ROW2:  row_reg[2] <= cfg_data;
                default:   ;
            endcase
        end
    end

    // pipeline advances unless the skid entry is occupied
    logic en;
    logic skid_valid_reg;
    assign en           = !skid_valid_reg;
    assign target_stall = !en;

    // stage 0: world difference
    logic signed [DW-1:0] d0_reg [3];
    logic v0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_reg[0] <= DW'(target.target_x) - DW'(pos_x_reg);
            d0_reg[1] <= DW'(target.target_y) - DW'(pos_y_reg);
            d0_reg[2] <= DW'(target.target_z) - DW'(pos_z_reg);
        end
    end

    // stage 1: nine products
    logic signed [PW-1:0] p1_reg [9];
    logic v1_reg;

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            logic signed [15:0] coef;
            assign coef = row_reg[r][16*c +: 16];
            always_ff @(posedge clk)
            begin
                if (en)
                    p1_reg[3*r+c] <= PW'(d0_reg[c]) * PW'(coef);
            end
        end
    end

    // stage 2: body vector
    logic signed [BW-1:0] b2_reg [3];
    logic v2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                b2_reg[r] <= BW'(p1_reg[3*r]) + BW'(p1_reg[3*r+1]) + BW'(p1_reg[3*r+2]);
            end
        end
    end

    // stage 3: magnitudes and their maximum
    logic [BW-1:0] ax, ay, az_m, mxy;
    logic [BW-1:0] ax3_reg, ay3_reg, az3_reg, m3_reg;
    logic signed [BW-1:0] bx3_reg, bz3_reg;
    logic byneg3_reg, zero3_reg, v3_reg;

    assign ax   = b2_reg[0][BW-1] ? BW'(-b2_reg[0]) : BW'(b2_reg[0]);
    assign ay   = b2_reg[1][BW-1] ? BW'(-b2_reg[1]) : BW'(b2_reg[1]);
    assign az_m = b2_reg[2][BW-1] ? BW'(-b2_reg[2]) : BW'(b2_reg[2]);
    assign mxy  = (ax > ay) ? ax : ay;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax3_reg    <= ax;
            ay3_reg    <= ay;
            az3_reg    <= az_m;
            m3_reg     <= (az_m > mxy) ? az_m : mxy;
            bx3_reg    <= b2_reg[0];
            bz3_reg    <= b2_reg[2];
            byneg3_reg <= b2_reg[1][BW-1];
            zero3_reg  <= (b2_reg[0] == '0) && (b2_reg[1] == '0) && (b2_reg[2] == '0);
        end
    end

    // stage 4: normalizing shift so the largest magnitude is below 2^29
    logic [5:0] hb;
    logic [4:0] sh_next;
    logic [4:0] sh4_reg;
    logic [BW-1:0] ax4_reg, ay4_reg, az4_reg;
    logic signed [BW-1:0] bx4_reg, bz4_reg;
    logic byneg4_reg, zero4_reg, v4_reg;

    always_comb
    begin
        hb = '0;
        for (int i = 0; i < BW; i++)
        begin
            if (m3_reg[i])
                hb = 6'(i + 1);
        end
        sh_next = (hb > 6'(SW)) ? 5'(hb - 6'(SW)) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh4_reg    <= sh_next;
            ax4_reg    <= ax3_reg;
            ay4_reg    <= ay3_reg;
            az4_reg    <= az3_reg;
            bx4_reg    <= bx3_reg;
            bz4_reg    <= bz3_reg;
            byneg4_reg <= byneg3_reg;
            zero4_reg  <= zero3_reg;
        end
    end

    // stage 5: scaled components
    logic [SW-1:0] ys_mag;
    az_tag_t tag5_reg;
    logic signed [BW-1:0] bx5_reg, bz5_reg;
    logic v5_reg;

    assign ys_mag = SW'(ay4_reg >> sh4_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag5_reg.xs   <= SW'(ax4_reg >> sh4_reg);
            tag5_reg.zs   <= SW'(az4_reg >> sh4_reg);
            tag5_reg.ys   <= byneg4_reg ? -$signed({1'b0, ys_mag}) : $signed({1'b0, ys_mag});
            tag5_reg.zero <= zero4_reg;
            bx5_reg       <= bx4_reg;
            bz5_reg       <= bz4_reg;
        end
    end

    // azimuth cordic on full-precision body x and z
    logic              azc_valid;
    logic [ACC_W-1:0]  azc_acc;
    logic [$bits(az_tag_t)-1:0] azc_tag_bits;
    az_tag_t           azc_tag;

    losa_cordic #(
        .W      (BW),
        .STAGES (CORDIC_STAGES),
        .TAG_W  ($bits(az_tag_t))
    ) u_az_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .x         (bx5_reg),
        .y         (bz5_reg),
        .tag       (tag5_reg),
        .out_valid (azc_valid),
        .acc       (azc_acc),
        .out_tag   (azc_tag_bits)
    );

    assign azc_tag = az_tag_t'(azc_tag_bits);

    // stage 6: azimuth negate, squares
    logic [ANGLE_W-1:0] az6_reg;
    logic [2*SW-1:0]    sqx6_reg, sqz6_reg;
    logic signed [SW:0] ys6_reg;
    logic zero6_reg, v6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            az6_reg   <= ANGLE_W'(0) - round16(azc_acc);
            sqx6_reg  <= (2*SW)'(azc_tag.xs) * (2*SW)'(azc_tag.xs);
            sqz6_reg  <= (2*SW)'(azc_tag.zs) * (2*SW)'(azc_tag.zs);
            ys6_reg   <= azc_tag.ys;
            zero6_reg <= azc_tag.zero;
        end
    end

    // square root: entry 0 holds the radicand, one result bit per stage
    logic [SQW-1:0]     sq_n_reg  [0:RT_ST];
    logic [SQW-1:0]     sq_r_reg  [0:RT_ST];
    logic signed [SW:0] sq_ys_reg [0:RT_ST];
    el_tag_t            sq_t_reg  [0:RT_ST];
    logic               sq_v_reg  [0:RT_ST];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_n_reg[0]       <= SQW'(sqx6_reg) + SQW'(sqz6_reg);
            sq_r_reg[0]       <= '0;
            sq_ys_reg[0]      <= ys6_reg;
            sq_t_reg[0].az    <= az6_reg;
            sq_t_reg[0].zero  <= zero6_reg;
        end
    end

    for (genvar j = 1; j <= RT_ST; j++)
    begin : g_sqrt
        localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 1 - 2*(j-1));
        logic [SQW:0] trial;
        assign trial = {1'b0, sq_r_reg[j-1]} + {1'b0, BIT};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[j] <= 1'b0;
            else if (en)
                sq_v_reg[j] <= sq_v_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_ys_reg[j] <= sq_ys_reg[j-1];
                sq_t_reg[j]  <= sq_t_reg[j-1];
                if ({1'b0, sq_n_reg[j-1]} >= trial)
                begin
                    sq_n_reg[j] <= sq_n_reg[j-1] - SQW'(trial);
                    sq_r_reg[j] <= (sq_r_reg[j-1] >> 1) + BIT;
                end
                else
                begin
                    sq_n_reg[j] <= sq_n_reg[j-1];
                    sq_r_reg[j] <= sq_r_reg[j-1] >> 1;
                end
            end
        end
    end

    // elevation cordic on (root, scaled y)
    logic signed [EW-1:0] el_x, el_y;
    logic              elc_valid;
    logic [ACC_W-1:0]  elc_acc;
    logic [$bits(el_tag_t)-1:0] elc_tag_bits;
    el_tag_t           elc_tag;

    assign el_x = $signed({1'b0, sq_r_reg[RT_ST][RW-1:0]});
    assign el_y = EW'(sq_ys_reg[RT_ST]);

    losa_cordic #(
        .W      (EW),
        .STAGES (CORDIC_STAGES),
        .TAG_W  ($bits(el_tag_t))
    ) u_el_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_v_reg[RT_ST]),
        .x         (el_x),
        .y         (el_y),
        .tag       (sq_t_reg[RT_ST]),
        .out_valid (elc_valid),
        .acc       (elc_acc),
        .out_tag   (elc_tag_bits)
    );

    assign elc_tag = el_tag_t'(elc_tag_bits);

    // final result: saturate elevation, zero both angles when degenerate
    logic signed [ANGLE_W-1:0] el_round;
    angles_t fin;

    assign el_round = round16(elc_acc);

    always_comb
    begin
        fin.degenerate = elc_tag.zero;
        if (elc_tag.zero)
        begin
            fin.azimuth   = '0;
            fin.elevation = '0;
        end
        else
        begin
            fin.azimuth = elc_tag.az;
            if (el_round > QUARTER_TURN)
                fin.elevation = QUARTER_TURN;
            else if (el_round < -QUARTER_TURN)
                fin.elevation = -QUARTER_TURN;
            else
                fin.elevation = el_round;
        end
    end

    // valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            sq_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v0_reg      <= target_valid;
            v1_reg      <= v0_reg;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= azc_valid;
            sq_v_reg[0] <= v6_reg;
        end
    end

    // output register plus skid entry
    logic    out_valid_reg;
    angles_t out_reg, skid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !angles_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= elc_valid;
        end
        else if (elc_valid && en)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !angles_stall)
            out_reg <= skid_valid_reg ? skid_reg : fin;
        else if (en)
            skid_reg <= fin;
    end

    assign angles_valid = out_valid_reg;
    assign angles       = out_reg;

    // skid entry only fills behind a held output beat
    `LOSA_ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid full with empty output")
    // degenerate beats carry zero angles
    `LOSA_ASSERT_IMPLY(a_degen_zero, clk, rst_n, angles_valid && angles.degenerate, (angles.azimuth == '0) && (angles.elevation == '0), "degenerate beat with nonzero angle")
    // elevation stays within a quarter turn
    `LOSA_ASSERT_IMPLY(a_el_range, clk, rst_n, angles_valid, (angles.elevation <= QUARTER_TURN) && (angles.elevation >= -QUARTER_TURN), "elevation out of range")
    // a full skid holds the front of the pipeline on the next edge
    `LOSA_ASSERT_NEXT(a_skid_holds, clk, rst_n, skid_valid_reg && angles_stall, $stable(v0_reg) && skid_valid_reg, "pipeline moved while skid full")

endmodule
